FILE: src/ole_pkg.sv
// Package for the ordered list engine: sizes, opcode and status codes,
// sequencer states and the structs passed between the list modules.
// No dependencies.
`timescale 1ns / 1ps

package ole_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [3:0] {
		OP_PUSHFRONT    = 4'd0,
		OP_PUSHBACK     = 4'd1,
		OP_POPFRONT     = 4'd2,
		OP_POPBACK      = 4'd3,
		OP_INSERTAT     = 4'd4,
		OP_ERASEAT      = 4'd5,
		OP_REMOVEALL    = 4'd6,
		OP_FIND         = 4'd7,
		OP_COUNT        = 4'd8,
		OP_SUM          = 4'd9,
		OP_ADDALL       = 4'd10,
		OP_SUBALL       = 4'd11,
		OP_SORTEDINSERT = 4'd12,
		OP_SORT         = 4'd13,
		OP_CLEAR        = 4'd14,
		OP_NOP          = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SHUP,
		S_PLACE,
		S_SHDN,
		S_MAP,
		S_BUB,
		S_SUMW,
		S_FIN
	} state_t;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		data_t wdata;
		idx_t  raddr;
	} mem_req_t;

	typedef struct packed {
		status_t status;
		logic    found;
		cnt_t    match_count;
		data_t   total;
		data_t   front;
		data_t   back;
		cnt_t    occupancy;
	} res_t;

	function automatic data_t to_data(logic [31:0] v);
		return DATA_WIDTH'(signed'(v));
	endfunction

	function automatic logic is_less(data_t a, data_t b);
		return a < b;
	endfunction

endpackage

FILE: src/ole_if.sv
// Valid/ready channel interfaces for the list engine command and response words.
// No dependencies.
`timescale 1ns / 1ps

interface ole_cmd_if;
	logic              valid;
	logic              ready;
	logic [3:0]        opcode;
	logic signed [31:0] value;
	logic [6:0]        position;

	modport source (output valid, output opcode, output value, output position, input ready);
	modport sink (input valid, input opcode, input value, input position, output ready);
endinterface

interface ole_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               found;
	logic [6:0]         match_count;
	logic signed [31:0] total;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;
	logic [6:0]         occupancy;

	modport source (output valid, output status, output found, output match_count,
		output total, output front_value, output back_value, output occupancy, input ready);
	modport sink (input valid, input status, input found, input match_count,
		input total, input front_value, input back_value, input occupancy, output ready);
endinterface

FILE: src/ole_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/ole_seq.sv
// Operation sequencer: walks the entry RAM through its registered read port,
// shifting, compacting, sorting and summing. Depends on ole_pkg.
`timescale 1ns / 1ps

module ole_seq
	import ole_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [3:0]  cmd_opcode,
	input  logic [31:0] cmd_value,
	input  logic [6:0]  cmd_position,
	input  logic        take,
	output logic        fin,
	output res_t        res,
	output mem_req_t    mem,
	input  data_t       rdata
);

	state_t  state_q, state_d;
	op_t     op_q, cmd_op;
	data_t   v_q, hold_q, sum_q, front_q, back_q;
	status_t stat_q;
	cnt_t    fill_q, idx_q, remain_q, a_q, k_q, cnt_q, len_q;
	logic    up_q, hit_q, vld_s1;
	idx_t    addr_s1;

	status_t p_status;
	state_t  p_state;
	cnt_t    p_idx, p_remain, p_a, pos_c;
	logic    p_up, full, empty, walking, walk_done, match;
	int      pos_i;

	assign cmd_op    = op_t'(cmd_opcode);
	assign full      = (fill_q == CNT_W'(CAPACITY));
	assign empty     = (fill_q == '0);
	assign pos_i     = int'(cmd_position);
	assign pos_c     = CNT_W'(cmd_position - 7'd1);
	assign walk_done = (remain_q == '0) && !vld_s1;
	assign match     = (rdata == v_q);
	assign walking   = (state_q == S_SCAN) || (state_q == S_SHUP) || (state_q == S_SHDN) ||
		(state_q == S_MAP) || (state_q == S_BUB) || (state_q == S_SUMW);

	// decode of an incoming word: refusal checks and the first walk
	always_comb begin
		p_status = ST_OK;
		p_state  = S_SUMW;
		p_idx    = '0;
		p_remain = fill_q;
		p_a      = '0;
		p_up     = 1'b1;
		case (cmd_op)
			OP_PUSHFRONT: begin
				if (full) begin
					p_status = ST_FULL;
				end else begin
					p_state = S_SHUP; p_a = fill_q - 1'b1; p_up = 1'b0;
				end
			end
			OP_PUSHBACK: begin
				if (full) begin
					p_status = ST_FULL;
				end else begin
					p_state = S_SHUP; p_idx = fill_q; p_remain = '0;
				end
			end
			OP_INSERTAT: begin
				if (full) begin
					p_status = ST_FULL;
				end else if (pos_i < 1 || pos_i > int'(fill_q) + 1) begin
					p_status = ST_BADPOS;
				end else begin
					p_state = S_SHUP; p_idx = pos_c; p_remain = fill_q - pos_c;
					p_a = fill_q - 1'b1; p_up = 1'b0;
				end
			end
			OP_POPFRONT: begin
				if (empty) begin
					p_status = ST_EMPTY;
				end else begin
					p_state = S_SHDN; p_remain = fill_q - 1'b1; p_a = CNT_W'(1);
				end
			end
			OP_POPBACK: begin
				if (empty) begin
					p_status = ST_EMPTY;
				end else begin
					p_state = S_SHDN; p_remain = '0;
				end
			end
			OP_ERASEAT: begin
				if (empty) begin
					p_status = ST_EMPTY;
				end else if (pos_i < 1 || pos_i > int'(fill_q)) begin
					p_status = ST_BADPOS;
				end else begin
					p_state = S_SHDN; p_remain = fill_q - 1'b1 - pos_c; p_a = pos_c + 1'b1;
				end
			end
			OP_REMOVEALL, OP_ADDALL, OP_SUBALL: begin
				p_state = S_MAP;
			end
			OP_FIND, OP_COUNT: begin
				p_state = S_SCAN;
			end
			OP_SORTEDINSERT: begin
				if (full) begin
					p_status = ST_FULL;
				end else begin
					p_state = S_SCAN; p_idx = fill_q;
				end
			end
			OP_SORT: begin
				if (fill_q > CNT_W'(1)) begin
					p_state = S_BUB;
				end
			end
			OP_CLEAR: begin
				p_remain = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		mem.we    = 1'b0;
		mem.waddr = '0;
		mem.wdata = rdata;
		mem.raddr = a_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = p_state;
				end
			end
			S_SCAN: begin
				if (walk_done) begin
					state_d = (op_q == OP_SORTEDINSERT) ? S_SHUP : S_SUMW;
				end
			end
			S_SHUP: begin
				if (vld_s1) begin
					mem.we = 1'b1; mem.waddr = addr_s1 + 1'b1;
				end
				if (walk_done) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				mem.we = 1'b1; mem.waddr = idx_q[IDX_W-1:0]; mem.wdata = v_q;
				state_d = S_SUMW;
			end
			S_SHDN: begin
				if (vld_s1) begin
					mem.we = 1'b1; mem.waddr = addr_s1 - 1'b1;
				end
				if (walk_done) begin
					state_d = S_SUMW;
				end
			end
			S_MAP: begin
				if (vld_s1) begin
					case (op_q)
						OP_ADDALL: begin
							mem.we = 1'b1; mem.waddr = addr_s1; mem.wdata = rdata + v_q;
						end
						OP_SUBALL: begin
							mem.we = 1'b1; mem.waddr = addr_s1; mem.wdata = rdata - v_q;
						end
						default: begin
							// compaction: survivors move down to the write pointer
							mem.we = !match; mem.waddr = k_q[IDX_W-1:0];
						end
					endcase
				end
				if (walk_done) begin
					state_d = S_SUMW;
				end
			end
			S_BUB: begin
				// one bubble pass; the running maximum rides in hold_q
				if (vld_s1 && addr_s1 != '0) begin
					mem.we    = 1'b1;
					mem.waddr = addr_s1 - 1'b1;
					mem.wdata = is_less(rdata, hold_q) ? rdata : hold_q;
				end
				if (walk_done) begin
					mem.we    = 1'b1;
					mem.waddr = IDX_W'(len_q - 1'b1);
					mem.wdata = hold_q;
					if (len_q <= CNT_W'(2)) begin
						state_d = S_SUMW;
					end
				end
			end
			S_SUMW: begin
				if (walk_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			remain_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= walking && (remain_q != '0);
			if (walking && remain_q != '0) begin
				remain_q <= remain_q - 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						remain_q <= p_remain;
						if (cmd_op == OP_CLEAR) begin
							fill_q <= '0;
						end
					end
				end
				S_SCAN: begin
					if (walk_done) begin
						remain_q <= (op_q == OP_SORTEDINSERT) ? fill_q - idx_q : fill_q;
					end
				end
				S_PLACE: begin
					fill_q   <= fill_q + 1'b1;
					remain_q <= fill_q + 1'b1;
				end
				S_SHDN: begin
					if (walk_done) begin
						fill_q   <= fill_q - 1'b1;
						remain_q <= fill_q - 1'b1;
					end
				end
				S_MAP: begin
					if (walk_done) begin
						if (op_q == OP_REMOVEALL) begin
							fill_q   <= k_q;
							remain_q <= k_q;
						end else begin
							remain_q <= fill_q;
						end
					end
				end
				S_BUB: begin
					if (walk_done) begin
						remain_q <= (len_q <= CNT_W'(2)) ? fill_q : len_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (walking && remain_q != '0) begin
			addr_s1 <= a_q[IDX_W-1:0];
			a_q     <= up_q ? a_q + 1'b1 : a_q - 1'b1;
		end
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					op_q    <= cmd_op;
					v_q     <= to_data(cmd_value);
					stat_q  <= p_status;
					idx_q   <= p_idx;
					a_q     <= p_a;
					up_q    <= p_up;
					cnt_q   <= '0;
					k_q     <= '0;
					hit_q   <= 1'b0;
					len_q   <= fill_q;
					sum_q   <= '0;
					front_q <= '0;
					back_q  <= '0;
				end
			end
			S_SCAN: begin
				if (vld_s1) begin
					if (match) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (!hit_q && !is_less(rdata, v_q)) begin
						hit_q <= 1'b1;
						idx_q <= CNT_W'(addr_s1);
					end
				end
				if (walk_done) begin
					// sorted insert shifts the tail up one slot, walking from the top; others go to the sum walk
					if (op_q == OP_SORTEDINSERT) begin
						a_q  <= fill_q - 1'b1;
						up_q <= 1'b0;
					end else begin
						a_q  <= '0;
						up_q <= 1'b1;
					end
				end
			end
			S_PLACE: begin
				a_q  <= '0;
				up_q <= 1'b1;
			end
			S_SHDN: begin
				if (walk_done) begin
					a_q  <= '0;
					up_q <= 1'b1;
				end
			end
			S_MAP: begin
				if (vld_s1 && op_q == OP_REMOVEALL) begin
					if (match) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				if (walk_done) begin
					a_q  <= '0;
					up_q <= 1'b1;
				end
			end
			S_BUB: begin
				if (vld_s1 && (addr_s1 == '0 || !is_less(rdata, hold_q))) begin
					hold_q <= rdata;
				end
				if (walk_done) begin
					len_q <= len_q - 1'b1;
					a_q   <= '0;
				end
			end
			S_SUMW: begin
				if (vld_s1) begin
					sum_q <= sum_q + rdata;
					if (addr_s1 == '0) begin
						front_q <= rdata;
					end
					if (CNT_W'(addr_s1) == fill_q - 1'b1) begin
						back_q <= rdata;
					end
				end
			end
			default: begin
			end
		endcase
	end

	logic counted;
	assign counted = (op_q == OP_REMOVEALL) || (op_q == OP_FIND) || (op_q == OP_COUNT);

	assign cmd_ready       = (state_q == S_IDLE);
	assign fin             = (state_q == S_FIN);
	assign res.status      = stat_q;
	assign res.found       = counted && (cnt_q != '0);
	assign res.match_count = counted ? cnt_q : '0;
	assign res.total       = sum_q;
	assign res.front       = front_q;
	assign res.back        = back_q;
	assign res.occupancy   = fill_q;

endmodule

FILE: src/ordered_list_engine_top.sv
// Top level of the ordered list engine: entry RAM, sequencer and response register.
// Depends on ole_pkg, ole_if, ole_ram and ole_seq.
`timescale 1ns / 1ps

// Bounded ordered list of up to 64 signed 32-bit values held in one
// single-port-write, registered-read RAM. One command word is taken at a time
// and yields one response word carrying status, match data, total, front,
// back and occupancy. Every command ends with a sum walk over the list.
// Pushes, pops, inserts and erases add one walk over the shifted tail, and
// pushes and inserts a place step that writes the word; find/count/remove/
// add/sub add one walk over the list, sorted insert a search walk plus a
// shift walk, and sort is a bubble sort through the RAM port. A new command
// is accepted while the previous response still waits in the output register;
// the next one then holds in its final state until that register drains.
// The RAM needs no clearing after reset.
module ordered_list_engine_top
	import ole_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	ole_cmd_if.sink  cmd,
	ole_rsp_if.source rsp
);

	mem_req_t mem;
	data_t    rdata;
	res_t     res, res_q;
	logic     fin, free, rsp_valid_q;

	ole_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	ole_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd.valid),
		.cmd_ready    (cmd.ready),
		.cmd_opcode   (cmd.opcode),
		.cmd_value    (cmd.value),
		.cmd_position (cmd.position),
		.take         (free),
		.fin          (fin),
		.res          (res),
		.mem          (mem),
		.rdata        (rdata)
	);

	assign free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin && free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin && free) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = res_q.status;
	assign rsp.found       = res_q.found;
	assign rsp.match_count = 7'(res_q.match_count);
	assign rsp.total       = 32'(res_q.total);
	assign rsp.front_value = 32'(res_q.front);
	assign rsp.back_value  = 32'(res_q.back);
	assign rsp.occupancy   = 7'(res_q.occupancy);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.occupancy <= 7'(CAPACITY))
		else $error("occupancy above capacity");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.occupancy == 7'(CAPACITY))
		else $error("full status with room left");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EMPTY |-> rsp.occupancy == 7'd0)
		else $error("empty status with entries held");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.found == (rsp.match_count != 7'd0))
		else $error("found flag disagrees with match count");

endmodule

FILE: sim/ole_list_checker.sv
// List checker: watches the command and response channels of the ordered list
// engine, keeps its own copy of the list and compares every response word.
// Depends on ole_pkg and ole_if.
`timescale 1ns / 1ps

module ole_list_checker
	import ole_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ole_cmd_if   cmd,
	ole_rsp_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   rsp_seen
);

	data_t list_q[$];
	res_t  want_q[$];

	function automatic res_t apply_cmd(op_t op, data_t v, int pos);
		res_t  r;
		data_t keep[$];
		data_t t;
		int    n, j, hits;
		logic  counted;
		r = '0;
		n = list_q.size();
		hits = 0;
		counted = 0;
		r.status = ST_OK;
		case (op)
			OP_PUSHFRONT: begin
				if (n >= CAPACITY) r.status = ST_FULL; else list_q.insert(0, v);
			end
			OP_PUSHBACK: begin
				if (n >= CAPACITY) r.status = ST_FULL; else list_q.insert(n, v);
			end
			OP_POPFRONT: begin
				if (n == 0) r.status = ST_EMPTY; else list_q.delete(0);
			end
			OP_POPBACK: begin
				if (n == 0) r.status = ST_EMPTY; else list_q.delete(n - 1);
			end
			OP_INSERTAT: begin
				if (n >= CAPACITY) r.status = ST_FULL;
				else if (pos < 1 || pos > n + 1) r.status = ST_BADPOS;
				else list_q.insert(pos - 1, v);
			end
			OP_ERASEAT: begin
				if (n == 0) r.status = ST_EMPTY;
				else if (pos < 1 || pos > n) r.status = ST_BADPOS;
				else list_q.delete(pos - 1);
			end
			OP_REMOVEALL, OP_FIND, OP_COUNT: begin
				counted = 1;
				foreach (list_q[i]) begin
					if (list_q[i] == v) hits++;
					else keep.insert(keep.size(), list_q[i]);
				end
				if (op == OP_REMOVEALL) list_q = keep;
			end
			OP_ADDALL: foreach (list_q[i]) list_q[i] = list_q[i] + v;
			OP_SUBALL: foreach (list_q[i]) list_q[i] = list_q[i] - v;
			OP_SORTEDINSERT: begin
				if (n >= CAPACITY) r.status = ST_FULL;
				else begin
					j = 0;
					while (j < n && list_q[j] < v) j++;
					list_q.insert(j, v);
				end
			end
			OP_SORT: begin
				// stable insertion sort, signed compare
				for (int i = 1; i < n; i++) begin
					t = list_q[i];
					j = i;
					while (j > 0 && t < list_q[j-1]) begin
						list_q[j] = list_q[j-1];
						j--;
					end
					list_q[j] = t;
				end
			end
			OP_CLEAR: list_q.delete();
			default: ;
		endcase
		n = list_q.size();
		r.found = counted && hits != 0;
		r.match_count = counted ? cnt_t'(hits) : '0;
		r.total = '0;
		foreach (list_q[i]) r.total = r.total + list_q[i];
		r.front = n ? list_q[0] : '0;
		r.back = n ? list_q[n-1] : '0;
		r.occupancy = cnt_t'(n);
		return r;
	endfunction

	task automatic report(string fld, longint want, longint got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch on word %0d, %s: expected %0d got %0d",
				$time, rsp_seen, fld, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t w;
		if (!arst_n) begin
			fail_count = 0;
			rsp_seen <= 0;
			pending <= 0;
			list_q.delete();
			want_q.delete();
		end else begin
			if (cmd.valid && cmd.ready)
				want_q.insert(want_q.size(), apply_cmd(op_t'(cmd.opcode),
					to_data(cmd.value), int'(cmd.position)));
			if (rsp.valid && rsp.ready) begin
				if (want_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("%0t unexpected response word", $time);
				end else begin
					w = want_q[0];
					want_q.delete(0);
					if (rsp.status != w.status) report("status", w.status, rsp.status);
					if (rsp.found != w.found) report("found", w.found, rsp.found);
					if (rsp.match_count != w.match_count)
						report("match_count", w.match_count, rsp.match_count);
					if (rsp.total != w.total) report("total", w.total, rsp.total);
					if (rsp.front_value != w.front) report("front", w.front, rsp.front_value);
					if (rsp.back_value != w.back) report("back", w.back, rsp.back_value);
					if (rsp.occupancy != w.occupancy)
						report("occupancy", w.occupancy, rsp.occupancy);
				end
				rsp_seen <= rsp_seen + 1;
			end
			pending <= want_q.size();
		end
	end

endmodule

FILE: sim/ordered_list_engine_top_test.sv
// Testbench top for the ordered list engine: directed and random command words,
// bursty sender, stalling receiver, verdict. Depends on ole_pkg, ole_if,
// ole_list_checker and ordered_list_engine_top.
`timescale 1ns / 1ps

module ordered_list_engine_top_test;
	import ole_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending, rsp_seen;
	int   sent = 0;
	longint cycles = 0;
	bit   long_hold = 0;
	bit   rsp_calm = 0;
	int   n_model = 0;

	ole_cmd_if cmd();
	ole_rsp_if rsp();

	ordered_list_engine_top i_dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));
	ole_list_checker i_chk (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp),
		.fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		cmd.valid = 0;
		cmd.opcode = '0;
		cmd.value = '0;
		cmd.position = '0;
		rsp.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver stall pattern; a long hold-off while the sender keeps offering
	always @(posedge clk) begin
		if (long_hold) rsp.ready <= 0;
		else if (rsp_calm) rsp.ready <= 1;
		else rsp.ready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		repeat (300) @(posedge clk);
		wait (sent > 400);
		@(posedge clk);
		long_hold = 1;
		repeat (400) @(posedge clk);
		long_hold = 0;
		wait (sent > 900);
		rsp_calm = 1;
		wait (sent > 1200);
		rsp_calm = 0;
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 7) - 3;
			3: return 32'(int'($urandom_range(0, 40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	// one command word; occupancy tracked loosely to steer positions
	task automatic send(op_t op, logic [31:0] v, logic [6:0] p);
		cmd.valid <= 1;
		cmd.opcode <= op;
		cmd.value <= v;
		cmd.position <= p;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		sent++;
		case (op)
			OP_PUSHFRONT, OP_PUSHBACK, OP_SORTEDINSERT: if (n_model < CAPACITY) n_model++;
			OP_POPFRONT, OP_POPBACK: if (n_model > 0) n_model--;
			OP_INSERTAT: if (n_model < CAPACITY && p >= 1 && p <= n_model + 1) n_model++;
			OP_ERASEAT: if (p >= 1 && p <= n_model) n_model--;
			OP_CLEAR: n_model = 0;
			default: ;
		endcase
	endtask

	task automatic gap();
		if ($urandom_range(0, 5) == 0) begin
			cmd.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	initial begin
		op_t op;
		logic [6:0] p;
		int burst;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty-list cases, extremes, bad positions
		send(OP_POPFRONT, 0, 1);
		send(OP_POPBACK, 0, 1);
		send(OP_ERASEAT, 0, 1);
		send(OP_SUM, 0, 0);
		send(OP_SORT, 0, 0);
		send(OP_INSERTAT, 5, 2);
		send(OP_INSERTAT, 32'h8000_0000, 1);
		send(OP_PUSHBACK, 32'h7fff_ffff, 0);
		send(OP_PUSHFRONT, 32'hffff_ffff, 127);
		send(OP_INSERTAT, 9, 4);
		send(OP_INSERTAT, 3, 3);
		send(OP_ERASEAT, 0, 0);
		send(OP_ERASEAT, 0, 5);
		send(OP_ERASEAT, 0, 2);
		send(OP_PUSHBACK, 32'h7fff_ffff, 64);
		send(OP_COUNT, 32'h7fff_ffff, 0);
		send(OP_FIND, 1234, 0);
		send(OP_ADDALL, 32'h7fff_ffff, 0);
		send(OP_SUBALL, 32'h8000_0000, 0);
		send(OP_SORTEDINSERT, 0, 0);
		send(OP_SORT, 0, 0);
		send(OP_REMOVEALL, 32'hffff_fffe, 0);
		send(OP_NOP, 32'h5555_aaaa, 7'h55);
		send(OP_CLEAR, 0, 0);
		// fill to capacity, then hit full cases
		while (n_model < CAPACITY) send(OP_PUSHBACK, pick_value(), 0);
		send(OP_PUSHFRONT, 1, 0);
		send(OP_INSERTAT, 1, 1);
		send(OP_SORTEDINSERT, 1, 0);
		send(OP_SORT, 0, 0);
		send(OP_ERASEAT, 0, 64);
		send(OP_ERASEAT, 0, 65);
		send(OP_CLEAR, 0, 0);
		// random: bursts with gaps, biased toward growth with occasional clears
		while (sent < 1935) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				case ($urandom_range(0, 19))
					0, 1, 2: op = OP_PUSHBACK;
					3, 4: op = OP_PUSHFRONT;
					5, 6: op = OP_INSERTAT;
					7, 8: op = OP_SORTEDINSERT;
					9: op = OP_ERASEAT;
					10: op = ($urandom_range(0, 1)) ? OP_POPFRONT : OP_POPBACK;
					11: op = OP_REMOVEALL;
					12: op = OP_FIND;
					13: op = OP_COUNT;
					14: op = OP_SUM;
					15: op = ($urandom_range(0, 1)) ? OP_ADDALL : OP_SUBALL;
					16: op = ($urandom_range(0, 3) == 0) ? OP_SORT : OP_PUSHBACK;
					17: op = ($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_ERASEAT;
					18: op = ($urandom_range(0, 4) == 0) ? OP_NOP : OP_INSERTAT;
					default: op = op_t'($urandom_range(0, 15));
				endcase
				if ($urandom_range(0, 9) == 0) p = 7'($urandom);
				else p = 7'($urandom_range(0, n_model + 1));
				send(op, pick_value(), p);
				gap();
			end
			cmd.valid <= 0;
			repeat ($urandom_range(0, 15)) @(posedge clk);
		end
		cmd.valid <= 0;
		// let the checker register the last accepted word before waiting on it
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("sent %0d command words, checked %0d response words", sent, rsp_seen);
		$display("covered all opcodes, full/empty/bad-position cases and a long output stall");
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
